### rtl/core/ale_pkg.sv
`default_nettype none
package ale_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int CNT_W         = 5;
   localparam int FUNC_W        = 3;
   localparam int STAT_W        = 2;

   localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

   localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_REVERSE = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_SORT    = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_POS  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_APPEND,
      CMD_INSERT,
      CMD_DELETE,
      CMD_TAGLOAD,
      CMD_EXCH
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXCH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      cell_cmd_type        cmd;
      logic                by_tag;
      logic                phase;
      logic [CNT_W-1:0]    count;
      logic [CNT_W-1:0]    slot;
      logic [DATA_W-1:0]   value;
   } cell_ctl_type;

endpackage
`default_nettype wire

### rtl/core/ale_cell.sv
`default_nettype none
module ale_cell import ale_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int INDEX = 0,
   localparam int TAG_W = $clog2(DEPTH),
   localparam int CW = ((TAG_W > CNT_W) ? TAG_W : CNT_W) + 1
) (
   input  wire logic                clock,
   input  wire cell_ctl_type        ctl,
   input  wire logic [DATA_W-1:0]   left_data,
   input  wire logic [TAG_W-1:0]    left_tag,
   input  wire logic [DATA_W-1:0]   right_data,
   input  wire logic [TAG_W-1:0]    right_tag,
   output logic [DATA_W-1:0]        data,
   output logic [TAG_W-1:0]         tag,
   output logic                     match
);

   localparam logic [CW-1:0] IDX = CW'(INDEX);
   localparam logic PAR = IDX[0];
   localparam bit HAS_LEFT = (INDEX > 0);

   logic [DATA_W-1:0] data_ff, data_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [CW-1:0]     cnt_w, slot_w;
   logic              less_r, less_l, swap_r, swap_l;

   assign cnt_w  = CW'(ctl.count);
   assign slot_w = CW'(ctl.slot);

   // compare-exchange with each neighbor; phase parity picks the pair
   assign less_r = ctl.by_tag ? (right_tag > tag_ff)
                              : ($signed(right_data) < $signed(data_ff));
   assign less_l = ctl.by_tag ? (tag_ff > left_tag)
                              : ($signed(data_ff) < $signed(left_data));
   assign swap_r = (ctl.phase == PAR) && ((IDX + 1'b1) < cnt_w) && less_r;
   assign swap_l = HAS_LEFT && (ctl.phase != PAR) && (IDX < cnt_w) && less_l;

   always_comb begin
      data_in = data_ff;
      tag_in  = tag_ff;
      unique case (ctl.cmd)
         CMD_HOLD: begin
         end
         CMD_APPEND: begin
            if (IDX == cnt_w) data_in = ctl.value;
         end
         CMD_INSERT: begin
            if (IDX == slot_w) begin
               data_in = ctl.value;
            end else if ((IDX > slot_w) && (IDX <= cnt_w)) begin
               data_in = left_data;
            end
         end
         CMD_DELETE: begin
            if ((IDX >= slot_w) && ((IDX + 1'b1) < cnt_w)) data_in = right_data;
         end
         CMD_TAGLOAD: begin
            tag_in = TAG_W'(INDEX);
         end
         CMD_EXCH: begin
            if (swap_r) begin
               data_in = right_data;
               tag_in  = right_tag;
            end else if (swap_l) begin
               data_in = left_data;
               tag_in  = left_tag;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      tag_ff  <= tag_in;
   end

   assign data  = data_ff;
   assign tag   = tag_ff;
   assign match = (data_ff == ctl.value);

endmodule
`default_nettype wire

### rtl/core/array_list_engine_core.sv
// Ordered list of up to DEPTH signed 32-bit values held in a row of cells,
// one entry per cell, each cell trading its word with its neighbors. One
// request in, one response out. Append, insert, delete and unused function
// codes update the cells as the request is taken, then load the response
// register. Search checks one cell match flag per cycle, from the first
// position on, until it finds the value or passes the last entry. Reverse
// and sort run count odd-even exchange phases across the cell row when
// count is at least 2, and skip them otherwise (reverse sorts on a loaded
// index tag). A new request is taken once the previous one has reached the
// response register, even while that response still waits; a response that
// is still held stalls the next one in the emit step until it is taken.
// The capacity register is clamped to 1..DEPTH.
`default_nettype none
module array_list_engine_core import ale_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [FUNC_W-1:0]          req_func,
   input  wire logic [CNT_W-1:0]           req_position,
   input  wire logic signed [DATA_W-1:0]   req_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [STAT_W-1:0]               rsp_status,
   output logic signed [DATA_W-1:0]        rsp_removed_value,
   output logic [CNT_W-1:0]                rsp_found_position,
   output logic [CNT_W-1:0]                rsp_entry_count,
   output logic                            rsp_full_flag,
   output logic                            rsp_empty_flag,
   input  wire logic                       csr_wr_en,
   input  wire logic [CNT_W-1:0]           csr_wr_data
);

   localparam int TAG_W  = $clog2(DEPTH);
   localparam int SCAN_W = TAG_W + 1;
   localparam int CW     = ((TAG_W > CNT_W) ? TAG_W : CNT_W) + 1;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    cap_ff;
   logic [DATA_W-1:0]   val_ff, val_in;
   logic                by_tag_ff, by_tag_in;
   logic [SCAN_W-1:0]   scan_ff, scan_in;
   logic [CNT_W-1:0]    phase_ff, phase_in;
   logic [STAT_W-1:0]   res_status_ff, res_status_in;
   logic [DATA_W-1:0]   res_removed_ff, res_removed_in;
   logic [CNT_W-1:0]    res_found_ff, res_found_in;

   logic                rsp_valid_ff;
   logic [STAT_W-1:0]   rsp_status_ff;
   logic [DATA_W-1:0]   rsp_removed_ff;
   logic [CNT_W-1:0]    rsp_found_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic                rsp_full_ff;
   logic                rsp_empty_ff;

   cell_ctl_type        ctl;
   logic [DATA_W-1:0]   cell_data [DEPTH];
   logic [TAG_W-1:0]    cell_tag  [DEPTH];
   logic [DEPTH-1:0]    cell_match;

   logic [CW-1:0]       cnt_w, pos_w, cap_eff, scan_w, slot_w;
   logic                full_now, at_depth, accept, emit_fire;

   assign cnt_w    = CW'(count_ff);
   assign pos_w    = CW'(req_position);
   assign scan_w   = CW'(scan_ff);
   assign slot_w   = pos_w - 1'b1;
   assign cap_eff  = (cap_ff == '0) ? CW'(1)
                   : ((CW'(cap_ff) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_ff));
   assign full_now = (cnt_w >= cap_eff);
   assign at_depth = (cnt_w >= CW'(DEPTH));

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int L = (i == 0) ? 0 : i - 1;
      localparam int R = (i == DEPTH - 1) ? i : i + 1;
      ale_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_data  (cell_data[L]),
         .left_tag   (cell_tag[L]),
         .right_data (cell_data[R]),
         .right_tag  (cell_tag[R]),
         .data       (cell_data[i]),
         .tag        (cell_tag[i]),
         .match      (cell_match[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      val_ff         <= val_in;
      by_tag_ff      <= by_tag_in;
      scan_ff        <= scan_in;
      phase_ff       <= phase_in;
      res_status_ff  <= res_status_in;
      res_removed_ff <= res_removed_in;
      res_found_ff   <= res_found_in;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      val_in         = val_ff;
      by_tag_in      = by_tag_ff;
      scan_in        = scan_ff;
      phase_in       = phase_ff;
      res_status_in  = res_status_ff;
      res_removed_in = res_removed_ff;
      res_found_in   = res_found_ff;
      ctl.cmd        = CMD_HOLD;
      ctl.by_tag     = by_tag_ff;
      ctl.phase      = phase_ff[0];
      ctl.count      = count_ff;
      ctl.slot       = req_position - 1'b1;
      ctl.value      = (state_ff == ST_IDLE) ? req_value : val_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_status_in  = STAT_OK;
               res_removed_in = '0;
               res_found_in   = '0;
               val_in         = req_value;
               phase_in       = '0;
               scan_in        = '0;
               state_in       = ST_EMIT;
               unique case (req_func)
                  FUNC_APPEND: begin
                     if (full_now || at_depth) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        ctl.cmd  = CMD_APPEND;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  FUNC_INSERT: begin
                     if ((pos_w == '0) || (pos_w > (cnt_w + 1'b1))) begin
                        res_status_in = STAT_BAD_POS;
                     end else if (full_now || at_depth) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        ctl.cmd  = CMD_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  FUNC_DELETE: begin
                     if ((pos_w == '0) || (pos_w > cnt_w)) begin
                        res_status_in = STAT_BAD_POS;
                     end else begin
                        res_removed_in = cell_data[slot_w[TAG_W-1:0]];
                        ctl.cmd        = CMD_DELETE;
                        count_in       = count_ff - 1'b1;
                     end
                  end
                  FUNC_SEARCH: begin
                     res_status_in = STAT_NOTFOUND;
                     state_in      = ST_SCAN;
                  end
                  FUNC_REVERSE: begin
                     ctl.cmd   = CMD_TAGLOAD;
                     by_tag_in = 1'b1;
                     if (cnt_w >= CW'(2)) state_in = ST_EXCH;
                  end
                  FUNC_SORT: begin
                     by_tag_in = 1'b0;
                     if (cnt_w >= CW'(2)) state_in = ST_EXCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_w >= cnt_w) begin
               state_in = ST_EMIT;
            end else if (cell_match[scan_ff[TAG_W-1:0]]) begin
               res_status_in = STAT_OK;
               res_found_in  = CNT_W'(scan_w + 1'b1);
               state_in      = ST_EMIT;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_EXCH: begin
            ctl.cmd = CMD_EXCH;
            if (phase_ff == (count_ff - 1'b1)) begin
               state_in = ST_EMIT;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (emit_fire) state_in = ST_IDLE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_status_ff  <= res_status_ff;
         rsp_removed_ff <= res_removed_ff;
         rsp_found_ff   <= res_found_ff;
         rsp_count_ff   <= count_ff;
         rsp_full_ff    <= full_now;
         rsp_empty_ff   <= (count_ff == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_value  = rsp_removed_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_full_flag      = rsp_full_ff;
   assign rsp_empty_flag     = rsp_empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_w <= CW'(DEPTH))
      else $error("entry count above depth");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("response raised outside emit state");

   a_count_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> $stable(count_ff))
      else $error("entry count changed while busy");

   a_found_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_found_ff != '0)) |-> (rsp_status_ff == STAT_OK))
      else $error("found position with non-ok status");

endmodule
`default_nettype wire
